### design/vfcm_pkg.sv
`timescale 1ns / 1ps

package vfcm_pkg;

    // Chunk geometry. The edge length is a power of two, so a cell index splits
    // into x, y and z bit fields.
    localparam int CHUNK_DIM  = 16;
    localparam int DIM_BITS   = $clog2(CHUNK_DIM);
    localparam int IDX_W      = 12;
    localparam int CELL_CAP   = 4096;
    localparam int CELL_TOTAL = (CHUNK_DIM * CHUNK_DIM * CHUNK_DIM > CELL_CAP) ?
                                CELL_CAP : CHUNK_DIM * CHUNK_DIM * CHUNK_DIM;

    // Field widths.
    localparam int TYPE_W   = 3;
    localparam int COORD_W  = 5;
    localparam int TEX_W    = 2;
    localparam int FACE_W   = 3;
    localparam int CNT_W    = 3;
    localparam int NUM_FACE = 6;
    localparam int NUM_VERT = 6;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    // Command queue between the front and back parts.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // Operation codes carried in s_axis_tuser.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_MESH  = 1'b1;

    localparam logic [TYPE_W-1:0] TYPE_EMPTY = '0;

    // Face codes.
    localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd0;
    localparam logic [FACE_W-1:0] FACE_POS_X = 3'd1;
    localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd2;
    localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd3;
    localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd4;
    localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd5;

    // Corner bits per face and vertex: bit 0 x, bit 1 y, bit 2 z.
    localparam logic [2:0] FACE_CORNER [0:NUM_FACE-1][0:NUM_VERT-1] = '{
        '{3'd4, 3'd6, 3'd2, 3'd2, 3'd0, 3'd4},
        '{3'd1, 3'd3, 3'd7, 3'd7, 3'd5, 3'd1},
        '{3'd4, 3'd0, 3'd1, 3'd1, 3'd5, 3'd4},
        '{3'd2, 3'd6, 3'd7, 3'd7, 3'd3, 3'd2},
        '{3'd0, 3'd2, 3'd3, 3'd3, 3'd1, 3'd0},
        '{3'd5, 3'd7, 3'd6, 3'd6, 3'd4, 3'd5}
    };

    // Texture corner per vertex: bit 0 u, bit 1 v.
    localparam logic [1:0] TEX_CORNER [0:NUM_VERT-1] = '{2'd0, 2'd2, 2'd3, 2'd3, 2'd1, 2'd0};

    // Atlas tile column and row per block type; unknown types use tile (0,0).
    localparam logic [TEX_W-1:0] TILE_U [0:7] = '{2'd0, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0};
    localparam logic [TEX_W-1:0] TILE_V [0:7] = '{2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd0};

    // One queued request.
    typedef struct packed {
        logic              mesh;
        logic [IDX_W-1:0]  idx;
        logic [TYPE_W-1:0] btype;
    } vfcm_cmd_t;

    // Queue head as seen by the back part.
    typedef struct packed {
        logic      valid;
        vfcm_cmd_t cmd;
    } vfcm_q_out_t;

    // Status from the back part to the front part.
    typedef struct packed {
        logic pop;
        logic clearing;
    } vfcm_back_stat_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } vfcm_state_t;

endpackage

### design/vfcm_front.sv
`timescale 1ns / 1ps

module vfcm_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [vfcm_pkg::IN_DATA_W-1:0] s_axis_tdata,  // cell_index[11:0], block_type[14:12]
    input  logic                          s_axis_tuser,  // op
    input  vfcm_pkg::vfcm_back_stat_t     bstat,
    output vfcm_pkg::vfcm_q_out_t         qout
);

    vfcm_pkg::vfcm_cmd_t                q_reg [0:vfcm_pkg::Q_DEPTH-1];
    logic [vfcm_pkg::Q_PTR_W-1:0]       wr_ptr_reg;
    logic [vfcm_pkg::Q_PTR_W-1:0]       rd_ptr_reg;
    logic [vfcm_pkg::Q_CNT_W-1:0]       count_reg;
    logic [vfcm_pkg::Q_CNT_W-1:0]       count_next;
    vfcm_pkg::vfcm_cmd_t                in_cmd;
    logic                               in_range;
    logic                               push;
    logic                               pop;

    // Unpack the request and drop indices beyond the chunk.
    always_comb
    begin
        in_cmd.mesh  = s_axis_tuser;
        in_cmd.idx   = s_axis_tdata[vfcm_pkg::IDX_W-1:0];
        in_cmd.btype = s_axis_tdata[vfcm_pkg::IDX_W +: vfcm_pkg::TYPE_W];
        in_range     = ({1'b0, in_cmd.idx} < (vfcm_pkg::IDX_W+1)'(vfcm_pkg::CELL_TOTAL));
    end

    // Requests are refused while the queue is full or the cell store is cleared.
    assign s_axis_tready = (count_reg != vfcm_pkg::Q_CNT_W'(vfcm_pkg::Q_DEPTH)) && !bstat.clearing;
    assign push          = s_axis_tvalid && s_axis_tready && in_range;
    assign pop           = bstat.pop && (count_reg != '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    assign qout.valid = (count_reg != '0);
    assign qout.cmd   = q_reg[rd_ptr_reg];

endmodule

### design/vfcm_back.sv
`timescale 1ns / 1ps

module vfcm_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  vfcm_pkg::vfcm_q_out_t             qin,
    output vfcm_pkg::vfcm_back_stat_t         bstat,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [vfcm_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tlast
);

    localparam int IW = vfcm_pkg::IDX_W;
    localparam int DB = vfcm_pkg::DIM_BITS;

    // Cell type store and its registered read port.
    logic [vfcm_pkg::TYPE_W-1:0]  cell_mem [0:vfcm_pkg::CELL_CAP-1];
    logic [vfcm_pkg::TYPE_W-1:0]  rd_data_reg;
    logic [IW-1:0]                rd_addr;
    logic                         mem_we;
    logic [IW-1:0]                mem_waddr;
    logic [vfcm_pkg::TYPE_W-1:0]  mem_wdata;

    vfcm_pkg::vfcm_state_t        state_reg, state_next;
    logic [IW-1:0]                clr_addr_reg, clr_addr_next;
    logic [IW-1:0]                idx_reg, idx_next;
    logic [vfcm_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                         nbr_ok_reg, nbr_ok_next;
    logic [vfcm_pkg::NUM_FACE-1:0] mask_reg, mask_next;
    logic [vfcm_pkg::FACE_W-1:0]  face_reg, face_next;
    logic [vfcm_pkg::CNT_W-1:0]   vert_reg, vert_next;
    logic [vfcm_pkg::TEX_W-1:0]   tu_reg, tu_next;
    logic [vfcm_pkg::TEX_W-1:0]   tv_reg, tv_next;
    logic                         out_valid_reg, out_valid_next;
    logic [vfcm_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic                         out_last_reg;

    logic                         pop;
    logic                         load;
    logic [vfcm_pkg::NUM_FACE-1:0] mask_upd;
    logic [vfcm_pkg::FACE_W:0]    pick_first;
    logic [vfcm_pkg::FACE_W:0]    pick_more;
    logic [IW:0]                  nbr_req;
    logic [2:0]                   corner;
    logic [1:0]                   tcorner;
    logic [vfcm_pkg::COORD_W-1:0] vx, vy, vz;
    logic [vfcm_pkg::TEX_W-1:0]   vu, vv;
    logic                         vlast;

    // Lowest face at or above start whose bit is set; result is {found, face}.
    function automatic logic [vfcm_pkg::FACE_W:0] pick_face(
        input logic [vfcm_pkg::NUM_FACE-1:0] mask,
        input logic [vfcm_pkg::FACE_W-1:0]   start
    );
        logic                        found;
        logic [vfcm_pkg::FACE_W-1:0] face;
        found = 1'b0;
        face  = '0;
        for (int i = 0; i < vfcm_pkg::NUM_FACE; i++)
        begin
            if (!found && mask[i] && (vfcm_pkg::FACE_W'(i) >= start))
            begin
                found = 1'b1;
                face  = vfcm_pkg::FACE_W'(i);
            end
        end
        return {found, face};
    endfunction

    // Neighbor address toward face k and whether it lies inside the chunk;
    // result is {inside, address}.
    function automatic logic [IW:0] neighbor(
        input logic [IW-1:0]                 idx,
        input logic [vfcm_pkg::FACE_W-1:0]   k
    );
        logic [DB-1:0] x, y, z;
        logic [DB-1:0] top;
        logic          ok;
        logic [IW-1:0] addr;
        x    = idx[DB-1:0];
        y    = idx[2*DB-1:DB];
        z    = idx[3*DB-1:2*DB];
        top  = DB'(vfcm_pkg::CHUNK_DIM - 1);
        ok   = 1'b0;
        addr = idx;
        case (k)
            vfcm_pkg::FACE_NEG_X:
            begin
                ok   = (x != '0);
                addr = idx - IW'(1);
            end
            vfcm_pkg::FACE_POS_X:
            begin
                ok   = (x != top);
                addr = idx + IW'(1);
            end
            vfcm_pkg::FACE_NEG_Y:
            begin
                ok   = (y != '0);
                addr = idx - IW'(vfcm_pkg::CHUNK_DIM);
            end
            vfcm_pkg::FACE_POS_Y:
            begin
                ok   = (y != top);
                addr = idx + IW'(vfcm_pkg::CHUNK_DIM);
            end
            vfcm_pkg::FACE_NEG_Z:
            begin
                ok   = (z != '0);
                addr = idx - IW'(vfcm_pkg::CHUNK_DIM * vfcm_pkg::CHUNK_DIM);
            end
            vfcm_pkg::FACE_POS_Z:
            begin
                ok   = (z != top);
                addr = idx + IW'(vfcm_pkg::CHUNK_DIM * vfcm_pkg::CHUNK_DIM);
            end
            default:
            begin
                ok   = 1'b0;
                addr = idx;
            end
        endcase
        return {ok, addr};
    endfunction

    // Vertex of the current face and corner, and whether it closes the cell.
    always_comb
    begin
        corner    = vfcm_pkg::FACE_CORNER[face_reg][vert_reg];
        tcorner   = vfcm_pkg::TEX_CORNER[vert_reg];
        vx        = vfcm_pkg::COORD_W'(idx_reg[DB-1:0]) + vfcm_pkg::COORD_W'(corner[0]);
        vy        = vfcm_pkg::COORD_W'(idx_reg[2*DB-1:DB]) + vfcm_pkg::COORD_W'(corner[1]);
        vz        = vfcm_pkg::COORD_W'(idx_reg[3*DB-1:2*DB]) + vfcm_pkg::COORD_W'(corner[2]);
        vu        = tu_reg + vfcm_pkg::TEX_W'(tcorner[0]);
        vv        = tv_reg + vfcm_pkg::TEX_W'(tcorner[1]);
        pick_more = pick_face(mask_reg, face_reg + 1'b1);
        vlast     = (vert_reg == vfcm_pkg::CNT_W'(vfcm_pkg::NUM_VERT - 1)) &&
                    !pick_more[vfcm_pkg::FACE_W];
    end

    // Sequencer: clearing pass, command dispatch, neighbor scan, vertex emission.
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        nbr_ok_next   = nbr_ok_reg;
        mask_next     = mask_reg;
        face_next     = face_reg;
        vert_next     = vert_reg;
        tu_next       = tu_reg;
        tv_next       = tv_reg;
        mem_we        = 1'b0;
        mem_waddr     = clr_addr_reg;
        mem_wdata     = vfcm_pkg::TYPE_EMPTY;
        rd_addr       = idx_reg;
        pop           = 1'b0;
        load          = 1'b0;
        mask_upd      = mask_reg;
        pick_first    = '0;
        nbr_req       = neighbor(idx_reg, cnt_reg);

        case (state_reg)
            vfcm_pkg::ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (clr_addr_reg == IW'(vfcm_pkg::CELL_CAP - 1))
                begin
                    state_next = vfcm_pkg::ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end

            vfcm_pkg::ST_IDLE:
            begin
                if (qin.valid)
                begin
                    pop = 1'b1;
                    if (qin.cmd.mesh == vfcm_pkg::OP_MESH)
                    begin
                        rd_addr    = qin.cmd.idx;
                        idx_next   = qin.cmd.idx;
                        cnt_next   = '0;
                        state_next = vfcm_pkg::ST_SCAN;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = qin.cmd.idx;
                        mem_wdata = qin.cmd.btype;
                    end
                end
            end

            vfcm_pkg::ST_SCAN:
            begin
                if (cnt_reg == '0)
                begin
                    // The read data is the cell itself.
                    if (rd_data_reg == vfcm_pkg::TYPE_EMPTY)
                    begin
                        state_next = vfcm_pkg::ST_IDLE;
                    end
                    else
                    begin
                        tu_next     = vfcm_pkg::TILE_U[rd_data_reg];
                        tv_next     = vfcm_pkg::TILE_V[rd_data_reg];
                        mask_next   = '0;
                        rd_addr     = nbr_req[IW-1:0];
                        nbr_ok_next = nbr_req[IW];
                        cnt_next    = cnt_reg + 1'b1;
                    end
                end
                else
                begin
                    // The read data is the neighbor issued in the previous cycle.
                    mask_upd[cnt_reg - 1'b1] = !(nbr_ok_reg && (rd_data_reg != vfcm_pkg::TYPE_EMPTY));
                    mask_next = mask_upd;
                    if (cnt_reg == vfcm_pkg::CNT_W'(vfcm_pkg::NUM_FACE))
                    begin
                        pick_first = pick_face(mask_upd, '0);
                        if (pick_first[vfcm_pkg::FACE_W])
                        begin
                            face_next  = pick_first[vfcm_pkg::FACE_W-1:0];
                            vert_next  = '0;
                            state_next = vfcm_pkg::ST_EMIT;
                        end
                        else
                        begin
                            state_next = vfcm_pkg::ST_IDLE;
                        end
                    end
                    else
                    begin
                        rd_addr     = nbr_req[IW-1:0];
                        nbr_ok_next = nbr_req[IW];
                        cnt_next    = cnt_reg + 1'b1;
                    end
                end
            end

            vfcm_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    load = 1'b1;
                    if (vert_reg == vfcm_pkg::CNT_W'(vfcm_pkg::NUM_VERT - 1))
                    begin
                        if (pick_more[vfcm_pkg::FACE_W])
                        begin
                            face_next = pick_more[vfcm_pkg::FACE_W-1:0];
                            vert_next = '0;
                        end
                        else
                        begin
                            state_next = vfcm_pkg::ST_IDLE;
                        end
                    end
                    else
                    begin
                        vert_next = vert_reg + 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = vfcm_pkg::ST_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vfcm_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers of the current cell.
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        nbr_ok_reg <= nbr_ok_next;
        mask_reg   <= mask_next;
        face_reg   <= face_next;
        vert_reg   <= vert_next;
        tu_reg     <= tu_next;
        tv_reg     <= tv_next;
        if (load)
        begin
            out_data_reg <= {2'b00, face_reg, vv, vu, vz, vy, vx};
            out_last_reg <= vlast;
        end
    end

    // Cell store.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= cell_mem[rd_addr];
    end

    assign bstat.pop      = pop;
    assign bstat.clearing = (state_reg == vfcm_pkg::ST_CLEAR);
    assign m_axis_tvalid  = out_valid_reg;
    assign m_axis_tdata   = out_data_reg;
    assign m_axis_tlast   = out_last_reg;

endmodule

### design/voxel_face_cull_mesher_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Signals                                   Contents
// s_axis    in         tvalid tready tdata[15:0] tuser           one cell write or mesh request
// m_axis    out        tvalid tready tdata[23:0] tlast           one face vertex
//
// A write is done by the back part straight from its idle state. A mesh request reads
// the cell and its six neighbors in turn through the single read port of the cell store,
// then emits six vertices per exposed face (up to 36 vertices), one vertex per cycle while m_axis_tready is high.
// After reset a clearing pass writes all 4096 cells to empty, one per cycle, while
// s_axis_tready stays low. A two-entry queue decouples request intake from meshing,
// and an output register holds a vertex while m_axis_tready is low.

module voxel_face_cull_mesher_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [vfcm_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // cell_index[11:0], block_type[14:12]
    input  logic                            s_axis_tuser,  // op
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // vert_x[4:0], vert_y[9:5], vert_z[14:10], tex_u[16:15], tex_v[18:17], face_dir[21:19]
    output logic [vfcm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast  // last
);

    vfcm_pkg::vfcm_q_out_t     qout;
    vfcm_pkg::vfcm_back_stat_t bstat;

    // Request intake and queue.
    vfcm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .bstat         (bstat),
        .qout          (qout)
    );

    // Cell store, neighbor scan and vertex emission.
    vfcm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .qin           (qout),
        .bstat         (bstat),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // No request is taken while the cell store is being cleared.
    assert property (@(posedge clk) disable iff (!rst_n) bstat.clearing |-> !s_axis_tready)
        else $error("request accepted during clearing pass");

    // A vertex that does not close its cell is followed at once by the next one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
        else $error("gap inside a cell's vertex run");

    // Emitted face codes stay within the six faces.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[21:19] <= vfcm_pkg::FACE_POS_Z))
        else $error("face code out of range");

    // Texture v never leaves the two atlas rows.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[18:17] <= 2'd2))
        else $error("texture v out of range");

    // The back part never pops the queue while the store is still being cleared.
    assert property (@(posedge clk) disable iff (!rst_n) bstat.clearing |-> !bstat.pop)
        else $error("queue popped during clearing pass");

endmodule

### tb/vfcm_vertex_checker.sv
`timescale 1ns / 1ps

module vfcm_vertex_checker
    import vfcm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // cell_index[11:0], block_type[14:12]
    input  logic                  s_axis_tuser,  // op
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // vert_x[4:0], vert_y[9:5], vert_z[14:10], tex_u[16:15], tex_v[18:17], face_dir[21:19]
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  m_axis_tlast,  // last
    output int                    fail_count,
    output int                    vertex_backlog
);

    // Block types that pick an atlas tile other than the default one.
    localparam logic [TYPE_W-1:0] BT_GREEN  = 3'd2;
    localparam logic [TYPE_W-1:0] BT_BLACK  = 3'd3;
    localparam logic [TYPE_W-1:0] BT_RED    = 3'd4;
    localparam logic [TYPE_W-1:0] BT_PURPLE = 3'd5;
    localparam logic [TYPE_W-1:0] BT_ORANGE = 3'd6;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [TEX_W-1:0]   u;
        logic [TEX_W-1:0]   v;
        logic [FACE_W-1:0]  face;
        logic               last;
    } vertex_t;

    vertex_t           awaited_vertices [$];
    logic [TYPE_W-1:0] chunk_cells [0:CELL_CAP-1];
    int                mismatches = 0;
    int                backlog = 0;
    vertex_t           want;
    vertex_t           seen;

    assign fail_count     = mismatches;
    assign vertex_backlog = backlog;

    // The chunk starts out empty.
    initial
    begin
        for (int i = 0; i < CELL_CAP; i++)
            chunk_cells[i] = TYPE_EMPTY;
    end

    // Corner codes of the six vertices of a face, vertex 0 in the lowest bits.
    // Bit 0 of a corner code adds one to x, bit 1 to y, bit 2 to z.
    function automatic logic [17:0] face_corners(input logic [FACE_W-1:0] face);
        case (face)
            FACE_NEG_X: return {3'd4, 3'd0, 3'd2, 3'd2, 3'd6, 3'd4};
            FACE_POS_X: return {3'd1, 3'd5, 3'd7, 3'd7, 3'd3, 3'd1};
            FACE_NEG_Y: return {3'd4, 3'd5, 3'd1, 3'd1, 3'd0, 3'd4};
            FACE_POS_Y: return {3'd2, 3'd3, 3'd7, 3'd7, 3'd6, 3'd2};
            FACE_NEG_Z: return {3'd0, 3'd1, 3'd3, 3'd3, 3'd2, 3'd0};
            default:    return {3'd5, 3'd4, 3'd6, 3'd6, 3'd7, 3'd5};
        endcase
    endfunction

    // Texture corner per vertex, vertex 0 in the lowest bits: bit 0 u, bit 1 v.
    localparam logic [11:0] TEX_CORNERS = {2'd0, 2'd1, 2'd3, 2'd3, 2'd2, 2'd0};

    function automatic logic [TEX_W-1:0] tile_column(input logic [TYPE_W-1:0] btype);
        case (btype)
            BT_GREEN, BT_PURPLE: return 2'd1;
            BT_BLACK, BT_ORANGE: return 2'd2;
            default:             return 2'd0;
        endcase
    endfunction

    function automatic logic [TEX_W-1:0] tile_row(input logic [TYPE_W-1:0] btype);
        case (btype)
            BT_RED, BT_PURPLE, BT_ORANGE: return 2'd1;
            default:                      return 2'd0;
        endcase
    endfunction

    // A face is drawn when the cell across it is empty or lies outside the chunk.
    function automatic bit face_exposed(input int x, input int y, input int z,
                                        input logic [FACE_W-1:0] face);
        int nx;
        int ny;
        int nz;
        int nidx;
        nx = x;
        ny = y;
        nz = z;
        case (face)
            FACE_NEG_X: nx = x - 1;
            FACE_POS_X: nx = x + 1;
            FACE_NEG_Y: ny = y - 1;
            FACE_POS_Y: ny = y + 1;
            FACE_NEG_Z: nz = z - 1;
            default:    nz = z + 1;
        endcase
        if (nx < 0 || ny < 0 || nz < 0)
            return 1'b1;
        if (nx >= CHUNK_DIM || ny >= CHUNK_DIM || nz >= CHUNK_DIM)
            return 1'b1;
        nidx = nx + ny * CHUNK_DIM + nz * CHUNK_DIM * CHUNK_DIM;
        if (nidx >= CELL_TOTAL)
            return 1'b1;
        return chunk_cells[nidx] == TYPE_EMPTY;
    endfunction

    // Queue up the vertices that meshing one cell should produce.
    function automatic void predict_face_vertices(input logic [IDX_W-1:0] idx);
        logic [TYPE_W-1:0] btype;
        logic [17:0]       corners;
        logic [2:0]        c;
        logic [1:0]        tc;
        vertex_t           vtx;
        int                x;
        int                y;
        int                z;
        int                final_face;
        if (idx >= CELL_TOTAL)
            return;
        btype = chunk_cells[idx];
        if (btype == TYPE_EMPTY)
            return;
        x = idx % CHUNK_DIM;
        y = (idx / CHUNK_DIM) % CHUNK_DIM;
        z = (idx / (CHUNK_DIM * CHUNK_DIM)) % CHUNK_DIM;
        final_face = -1;
        for (int f = 0; f < NUM_FACE; f++)
            if (face_exposed(x, y, z, FACE_W'(f)))
                final_face = f;
        for (int f = 0; f < NUM_FACE; f++)
        begin
            if (face_exposed(x, y, z, FACE_W'(f)))
            begin
                corners = face_corners(FACE_W'(f));
                for (int v = 0; v < NUM_VERT; v++)
                begin
                    c        = corners[v*3 +: 3];
                    tc       = TEX_CORNERS[v*2 +: 2];
                    vtx.x    = COORD_W'(x + c[0]);
                    vtx.y    = COORD_W'(y + c[1]);
                    vtx.z    = COORD_W'(z + c[2]);
                    vtx.u    = tile_column(btype) + tc[0];
                    vtx.v    = tile_row(btype) + tc[1];
                    vtx.face = FACE_W'(f);
                    vtx.last = (f == final_face) && (v == NUM_VERT - 1);
                    awaited_vertices.push_back(vtx);
                end
            end
        end
    endfunction

    task automatic check_field(input string field, input int expected_val, input int actual_val);
        if (expected_val != actual_val)
        begin
            $error("%s mismatch: expected %0d, actual %0d", field, expected_val, actual_val);
            mismatches++;
        end
    endtask

    // Check each vertex leaving the block, then track each accepted request.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.x    = m_axis_tdata[4:0];
                seen.y    = m_axis_tdata[9:5];
                seen.z    = m_axis_tdata[14:10];
                seen.u    = m_axis_tdata[16:15];
                seen.v    = m_axis_tdata[18:17];
                seen.face = m_axis_tdata[21:19];
                seen.last = m_axis_tlast;
                if (awaited_vertices.size() == 0)
                begin
                    $error("vertex with none awaited: tdata %h, tlast %b",
                           m_axis_tdata, m_axis_tlast);
                    mismatches++;
                end
                else
                begin
                    want = awaited_vertices.pop_front();
                    check_field("vert_x", want.x, seen.x);
                    check_field("vert_y", want.y, seen.y);
                    check_field("vert_z", want.z, seen.z);
                    check_field("tex_u", want.u, seen.u);
                    check_field("tex_v", want.v, seen.v);
                    check_field("face_dir", want.face, seen.face);
                    check_field("last", want.last, seen.last);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == OP_WRITE)
                begin
                    if (s_axis_tdata[11:0] < CELL_TOTAL)
                        chunk_cells[s_axis_tdata[11:0]] = s_axis_tdata[14:12];
                end
                else
                begin
                    predict_face_vertices(s_axis_tdata[11:0]);
                end
            end
            backlog <= awaited_vertices.size();
        end
    end

endmodule

### tb/tb_voxel_face_cull_mesher_top.sv
`timescale 1ns / 1ps

module tb_voxel_face_cull_mesher_top;

    import vfcm_pkg::*;

    localparam int     RX_HOLD_CYCLES = 400;
    localparam int     SETTLE_CYCLES  = 200;
    localparam longint TIMEOUT_NS     = 10_000_000;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // cell_index[11:0], block_type[14:12]
    logic                  s_axis_tuser;   // op
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // vert_x[4:0], vert_y[9:5], vert_z[14:10], tex_u[16:15], tex_v[18:17], face_dir[21:19]
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;   // last

    int fail_count;
    int vertex_backlog;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int rx_hold_seq    = 0;
    int rx_hold_seen   = 0;
    int rx_hold_left   = 0;

    voxel_face_cull_mesher_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    vfcm_vertex_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .fail_count     (fail_count),
        .vertex_backlog (vertex_backlog)
    );

    // Free-running clock.
    initial
        clk = 1'b0;
    always #10 clk = ~clk;

    // Output side: random stalls, plus a long hold-off whenever one is requested.
    always @(negedge clk)
    begin
        if (rx_hold_seen != rx_hold_seq)
        begin
            rx_hold_seen = rx_hold_seq;
            rx_hold_left = RX_HOLD_CYCLES;
        end
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [IDX_W-1:0] cell_at(input int x, input int y, input int z);
        return IDX_W'(x + y * CHUNK_DIM + z * CHUNK_DIM * CHUNK_DIM);
    endfunction

    // Corner of a 3x3x3 region, often placed against a chunk boundary.
    function automatic int region_base();
        case ($urandom_range(3))
            0:       return 0;
            1:       return CHUNK_DIM - 3;
            default: return $urandom_range(CHUNK_DIM - 3);
        endcase
    endfunction

    // Offer one request after a random gap and wait until it is taken.
    task automatic offer(input logic op, input logic [IDX_W-1:0] idx,
                         input logic [TYPE_W-1:0] btype);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {1'b0, btype, idx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Stop sending until every awaited vertex is out and the block has gone quiet.
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (vertex_backlog != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // Fill part of a small region with random types, then mesh a few of its cells.
    task automatic region_burst(inout int sent);
        int bx;
        int by;
        int bz;
        bx = region_base();
        by = region_base();
        bz = region_base();
        repeat ($urandom_range(3, 8))
        begin
            offer(OP_WRITE,
                  cell_at(bx + $urandom_range(2), by + $urandom_range(2), bz + $urandom_range(2)),
                  ($urandom_range(99) < 15) ? TYPE_EMPTY : TYPE_W'($urandom_range(1, 7)));
            sent++;
        end
        repeat ($urandom_range(1, 4))
        begin
            offer(OP_MESH,
                  cell_at(bx + $urandom_range(2), by + $urandom_range(2), bz + $urandom_range(2)),
                  TYPE_W'($urandom()));
            sent++;
        end
    endtask

    // One random phase: mostly region bursts, some unrelated requests anywhere.
    task automatic random_phase(input int idle_pct, input int stall_pct, input int count);
        int sent;
        sent           = 0;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (sent < count)
        begin
            if ($urandom_range(99) < 20)
            begin
                offer(1'($urandom()), IDX_W'($urandom()), TYPE_W'($urandom()));
                sent++;
            end
            else
            begin
                region_burst(sent);
            end
        end
        settle();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = OP_WRITE;
        s_axis_tdata  = '0;
        repeat (12)
            @(negedge clk);
        rst_n = 1'b1;

        // Meshing an empty cell produces nothing.
        offer(OP_MESH, cell_at(0, 0, 0), TYPE_W'($urandom()));
        // Every block type, including the unknown one, at the chunk origin.
        for (int t = 1; t < (1 << TYPE_W); t++)
        begin
            offer(OP_WRITE, cell_at(0, 0, 0), TYPE_W'(t));
            offer(OP_MESH, cell_at(0, 0, 0), TYPE_W'($urandom()));
        end
        // Far corner, where vertex coordinates reach the chunk edge length.
        offer(OP_WRITE, cell_at(CHUNK_DIM - 1, CHUNK_DIM - 1, CHUNK_DIM - 1), 3'd6);
        offer(OP_MESH, cell_at(CHUNK_DIM - 1, CHUNK_DIM - 1, CHUNK_DIM - 1), 3'd0);
        // A cell enclosed on all six sides produces nothing.
        offer(OP_WRITE, cell_at(5, 5, 5), 3'd2);
        offer(OP_WRITE, cell_at(4, 5, 5), 3'd3);
        offer(OP_WRITE, cell_at(6, 5, 5), 3'd4);
        offer(OP_WRITE, cell_at(5, 4, 5), 3'd5);
        offer(OP_WRITE, cell_at(5, 6, 5), 3'd1);
        offer(OP_WRITE, cell_at(5, 5, 4), 3'd7);
        offer(OP_WRITE, cell_at(5, 5, 6), 3'd6);
        offer(OP_MESH, cell_at(5, 5, 5), 3'd0);
        settle();

        random_phase(0, 0, 25);
        random_phase(74, 0, 25);
        random_phase(0, 74, 25);
        random_phase(31, 31, 25);

        // Back-pressure: the output side holds off while mesh requests for the two corner cells keep coming.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        offer(OP_WRITE, cell_at(0, 0, 0), 3'd5);
        offer(OP_WRITE, cell_at(CHUNK_DIM - 1, CHUNK_DIM - 1, CHUNK_DIM - 1), 3'd4);
        settle();
        rx_hold_seq++;
        for (int i = 0; i < 10; i++)
            offer(OP_MESH, (i % 2 == 0) ? cell_at(0, 0, 0) :
                  cell_at(CHUNK_DIM - 1, CHUNK_DIM - 1, CHUNK_DIM - 1), TYPE_W'($urandom()));
        settle();

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
